[sv/ttb_pkg.sv]
// Types and constants shared by the tangent/bitangent block.
// Depends on nothing.
`timescale 1ns / 1ps
package ttb_pkg;
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [23:0] tex_u;
        logic signed [23:0] tex_v;
    } t_vertex;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic signed [31:0] bitangent_x;
        logic signed [31:0] bitangent_y;
        logic signed [31:0] bitangent_z;
        logic               degenerate;
    } t_result;

    localparam int DIV_W = 64;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  den;
    } t_div_req;
endpackage

[sv/ttb_div.sv]
// Restoring divider, one quotient bit per cycle, saturating to 32 bits signed.
// Depends on ttb_pkg.
`timescale 1ns / 1ps
module ttb_div import ttb_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    localparam int NB = DIV_W + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0]    r_dvd;
    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_den;
    logic [32:0]      r_q;
    logic             r_big, r_neg, r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W:0]   w_sh, w_sub;
    logic [32:0]      w_q;
    logic             w_ge;

    assign w_sh  = {r_rem[DIV_W-1:0], r_dvd[NB-1]};
    assign w_ge  = w_sh >= {1'b0, r_den};
    assign w_sub = w_ge ? w_sh - {1'b0, r_den} : w_sh;
    assign w_q   = {r_q[31:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_dvd  <= {i_req.num, {FRAC_BITS{1'b0}}};
                r_den  <= i_req.den;
                r_neg  <= i_req.neg;
                r_rem  <= '0;
                r_q    <= '0;
                r_big  <= 1'b0;
                r_cnt  <= CW'(NB);
            end else if (r_busy) begin
                r_dvd <= r_dvd << 1;
                r_rem <= w_sub;
                if (w_q[32] || r_big) begin
                    r_big <= 1'b1;
                    r_q   <= 33'h0_FFFF_FFFF;
                end else begin
                    r_q <= w_q;
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_big || r_q[31]) o_quot = 32'sh8000_0000;
            else o_quot = -$signed(r_q[31:0]);
        end else begin
            if (r_big || r_q[31]) o_quot = 32'sh7FFF_FFFF;
            else o_quot = $signed(r_q[31:0]);
        end
    end

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("div done while busy");
endmodule

[sv/triangle_tangent_bitangent.sv]
// Top level: vertex capture, shared multiplier sequencer and divider control.
// Depends on ttb_pkg and ttb_div.
//
// channel | dir | payload  | handshake
// vertex  | in  | t_vertex | i_in_valid / o_in_stall
// result  | out | t_result | o_out_valid / i_out_stall
//
// First two vertices of a triangle are only registered.
// Third vertex: 14 steps on one 33x25 multiplier, then six divisions through one
// bit-serial divider, result valid after the sixth. Degenerate triangle (zero det):
// zeroed result with degenerate flag, no division. The result register holds under
// stall; no new vertex is taken until it is transferred. Synchronous active-low reset.
`timescale 1ns / 1ps
module triangle_tangent_bitangent import ttb_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_vertex i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_data
);
    localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_DIVGO = 3'd2,
                           S_DIVW = 3'd3, S_OUT = 3'd4;

    logic [2:0]  r_state;
    logic [1:0]  r_cnt;
    logic [3:0]  r_step;
    logic [2:0]  r_k;
    logic signed [31:0] r_p0 [3];
    logic signed [31:0] r_p1 [3];
    logic signed [23:0] r_u0, r_v0, r_u1, r_v1;
    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic signed [24:0] r_du1, r_du2, r_dv1, r_dv2;
    logic signed [DIV_W-1:0] r_det;
    logic signed [DIV_W-1:0] r_num [6];
    logic signed [DIV_W-1:0] r_prod;
    logic signed [32:0]      w_ma;
    logic signed [24:0]      w_mb;
    logic signed [57:0]      w_prod;
    logic [1:0]  w_ki;
    t_div_req    w_req;
    logic        w_done;
    logic signed [31:0] w_quot;
    logic signed [DIV_W-1:0] w_nk;
    logic        w_acc;

    assign w_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign w_ki = (r_k < 3'd3) ? r_k[1:0] : 2'(r_k - 3'd3);

    // multiplier operand select: steps 0,1 det; 2..13 numerators (two per value)
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_step == 4'd0) begin
            w_ma = 33'(r_du1);
            w_mb = r_dv2;
        end else if (r_step == 4'd1) begin
            w_ma = 33'(r_du2);
            w_mb = r_dv1;
        end else if (r_k < 3'd3) begin
            if (!r_step[0]) begin
                w_ma = r_e1[w_ki];
                w_mb = r_dv2;
            end else begin
                w_ma = r_e2[w_ki];
                w_mb = r_dv1;
            end
        end else begin
            if (!r_step[0]) begin
                w_ma = r_e2[w_ki];
                w_mb = r_du1;
            end else begin
                w_ma = r_e1[w_ki];
                w_mb = r_du2;
            end
        end
    end

    assign w_prod = w_ma * w_mb;

    assign w_nk = r_num[r_k];

    always_comb begin
        w_req.start = (r_state == S_DIVGO);
        w_req.neg   = w_nk[DIV_W-1] ^ r_det[DIV_W-1];
        w_req.num   = w_nk[DIV_W-1] ? -w_nk : w_nk;
        w_req.den   = r_det[DIV_W-1] ? -r_det : r_det;
    end

    ttb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (r_cnt < 2'd2) begin
                            if (r_cnt[0]) begin
                                r_p1[0] <= i_in_data.pos_x;
                                r_p1[1] <= i_in_data.pos_y;
                                r_p1[2] <= i_in_data.pos_z;
                                r_u1 <= i_in_data.tex_u;
                                r_v1 <= i_in_data.tex_v;
                            end else begin
                                r_p0[0] <= i_in_data.pos_x;
                                r_p0[1] <= i_in_data.pos_y;
                                r_p0[2] <= i_in_data.pos_z;
                                r_u0 <= i_in_data.tex_u;
                                r_v0 <= i_in_data.tex_v;
                            end
                            r_cnt <= r_cnt + 2'd1;
                        end else begin
                            r_cnt <= '0;
                            r_e1[0] <= 33'(r_p1[0]) - 33'(r_p0[0]);
                            r_e1[1] <= 33'(r_p1[1]) - 33'(r_p0[1]);
                            r_e1[2] <= 33'(r_p1[2]) - 33'(r_p0[2]);
                            r_e2[0] <= 33'(i_in_data.pos_x) - 33'(r_p0[0]);
                            r_e2[1] <= 33'(i_in_data.pos_y) - 33'(r_p0[1]);
                            r_e2[2] <= 33'(i_in_data.pos_z) - 33'(r_p0[2]);
                            r_du1 <= 25'(r_u1) - 25'(r_u0);
                            r_du2 <= 25'(i_in_data.tex_u) - 25'(r_u0);
                            // flipped v: (1-a)-(1-b) = b-a
                            r_dv1 <= 25'(r_v0) - 25'(r_v1);
                            r_dv2 <= 25'(r_v0) - 25'(i_in_data.tex_v);
                            r_step <= '0;
                            r_k <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 4'd1;
                    if (!r_step[0]) begin
                        r_prod <= DIV_W'(w_prod);
                    end else if (r_step == 4'd1) begin
                        r_det <= r_prod - DIV_W'(w_prod);
                    end else begin
                        r_num[r_k] <= r_prod - DIV_W'(w_prod);
                        if (r_k == 3'd5) begin
                            r_k <= '0;
                            if (r_det == '0) begin
                                o_out_data  <= {{6{32'd0}}, 1'b1};
                                o_out_valid <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                o_out_data.degenerate <= 1'b0;
                                r_state <= S_DIVGO;
                            end
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                S_DIVGO: r_state <= S_DIVW;
                S_DIVW: begin
                    if (w_done) begin
                        case (r_k)
                            3'd0: o_out_data.tangent_x   <= w_quot;
                            3'd1: o_out_data.tangent_y   <= w_quot;
                            3'd2: o_out_data.tangent_z   <= w_quot;
                            3'd3: o_out_data.bitangent_x <= w_quot;
                            3'd4: o_out_data.bitangent_y <= w_quot;
                            default: o_out_data.bitangent_z <= w_quot;
                        endcase
                        if (r_k == 3'd5) begin
                            o_out_valid <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_k <= r_k + 3'd1;
                            r_state <= S_DIVGO;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("corner count out of range");
    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == S_OUT) else $error("valid outside output state");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.degenerate) |-> o_out_data.tangent_x == 0)
        else $error("degenerate result not zeroed");
endmodule
